[hdl/cuq_pkg.sv]
// Shared constants, item types and helpers for the coalescing update queue.
package cuq_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int TILE_LIMIT  = 32;
  localparam int HANDLE_BITS = 32;

  localparam int PTR_W   = $clog2(QUEUE_SLOTS);
  localparam int ENTRY_W = 3 + 8 + HANDLE_BITS;

  // result status codes
  localparam logic [2:0] ST_COALESCED = 3'd0;
  localparam logic [2:0] ST_APPENDED  = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_DELIVERED = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  // input command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DRAIN   = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic                   cmd;
    logic [2:0]             group_kind;
    logic [7:0]             slot_index;
    logic [31:0]            payload_handle;
    logic [7:0]             drain_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [2:0]             out_group_kind;
    logic [7:0]             out_slot_index;
    logic [31:0]            out_payload_handle;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]             group_kind;
    logic [7:0]             slot_index;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       take_item;    // latch input item, start scan at oldest entry
    logic       scan_step;    // move scan pointer one entry on
    logic       wr_coalesce;  // overwrite entry under scan pointer
    logic       wr_append;    // write at tail, drop oldest when full
    logic       pop;          // retire oldest entry (drain)
    logic       out_load;     // load output register
    logic [2:0] out_code;
    logic       out_last;
  } cuq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_drain;
    logic reject;
    logic empty;
    logic cur_at_end;
    logic scan_end;
    logic hit;
    logic full;
    logic drain_last;
    logic out_free;
  } cuq_stat_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic logic [HANDLE_BITS-1:0] to_handle(input logic [31:0] h);
    logic [63:0] w;
    w = 64'(h);
    to_handle = w[HANDLE_BITS-1:0];
  endfunction

  function automatic logic [31:0] handle_out(input logic [HANDLE_BITS-1:0] h);
    logic [63:0] w;
    w = 64'(h);
    handle_out = w[31:0];
  endfunction

endpackage

[hdl/cuq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cuq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/cuq_ctrl.sv]
// Sequencing state machine for enqueue scans and drains.
module cuq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cuq_pkg::cuq_stat_t stat,
  output cuq_pkg::cuq_cmd_t  cmd
);
  import cuq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_DOUT   = 3'd5;
  localparam logic [2:0] S_DWAIT  = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE) && stat.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take_item = 1'b1;
          state_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.is_drain) begin
          if (stat.empty) begin
            cmd.out_load = 1'b1;
            cmd.out_code = ST_EMPTY;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_DOUT;
          end
        end else if (stat.reject) begin
          cmd.out_load = 1'b1;
          cmd.out_code = ST_REJECTED;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.cur_at_end) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.hit) begin
          cmd.wr_coalesce = 1'b1;
          cmd.out_load    = 1'b1;
          cmd.out_code    = ST_COALESCED;
          cmd.out_last    = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
          state_next    = stat.scan_end ? S_APPEND : S_RDWAIT;
        end
      end
      S_RDWAIT: state_next = S_CMP;
      S_APPEND: begin
        cmd.wr_append = 1'b1;
        cmd.out_load  = 1'b1;
        cmd.out_code  = stat.full ? ST_DROPPED : ST_APPENDED;
        cmd.out_last  = 1'b1;
        state_next    = S_IDLE;
      end
      S_DOUT: begin
        if (stat.out_free) begin
          cmd.pop      = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_code = ST_DELIVERED;
          cmd.out_last = stat.drain_last;
          state_next   = stat.drain_last ? S_IDLE : S_DWAIT;
        end
      end
      S_DWAIT: state_next = S_DOUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/cuq_datapath.sv]
// Pointers, item and output registers, entry store and compare logic.
module cuq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  cuq_pkg::in_item_t  in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output cuq_pkg::out_item_t out_data,
  input  cuq_pkg::cuq_cmd_t  cmd,
  output cuq_pkg::cuq_stat_t stat
);
  import cuq_pkg::*;

  in_item_t  item;
  ptr_t      wp, rp, cur;
  logic [7:0] cnt;
  entry_t    rd_entry, wr_entry;
  logic [ENTRY_W-1:0] rdata;
  logic      ram_we;
  ptr_t      ram_waddr;
  ptr_t      rp_nx, wp_nx, cur_nx;
  logic [7:0] cnt_inc;

  assign rp_nx   = ring_next(rp);
  assign wp_nx   = ring_next(wp);
  assign cur_nx  = ring_next(cur);
  assign cnt_inc = 8'(cnt + 8'd1);

  assign wr_entry  = '{group_kind: item.group_kind, slot_index: item.slot_index,
                       handle: to_handle(item.payload_handle)};
  assign ram_we    = cmd.wr_coalesce || cmd.wr_append;
  assign ram_waddr = cmd.wr_append ? wp : cur;
  assign rd_entry  = entry_t'(rdata);

  // read address follows the scan/drain pointer; read data is registered
  cuq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_SLOTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENTRY_W'(wr_entry)),
    .raddr (cur),
    .rdata (rdata)
  );

  always_comb begin
    stat.is_drain   = (item.cmd == CMD_DRAIN);
    stat.reject     = ({1'b0, item.slot_index} >= 9'(TILE_LIMIT)) ||
                      (to_handle(item.payload_handle) == '0);
    stat.empty      = (rp == wp);
    stat.cur_at_end = (cur == wp);
    stat.scan_end   = (cur_nx == wp);
    stat.hit        = (rd_entry.group_kind == item.group_kind) &&
                      (rd_entry.slot_index == item.slot_index);
    stat.full       = (wp_nx == rp);
    stat.drain_last = (rp_nx == wp) ||
                      ((item.drain_limit != 8'd0) && (cnt_inc == item.drain_limit));
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item <= in_data;
    end
    if (cmd.out_load) begin
      out_data.status <= cmd.out_code;
      out_data.last   <= cmd.out_last;
      if (cmd.pop) begin
        out_data.out_group_kind     <= rd_entry.group_kind;
        out_data.out_slot_index     <= rd_entry.slot_index;
        out_data.out_payload_handle <= handle_out(rd_entry.handle);
      end else begin
        out_data.out_group_kind     <= '0;
        out_data.out_slot_index     <= '0;
        out_data.out_payload_handle <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      cur       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take_item) begin
        cur <= rp;
        cnt <= '0;
      end else if (cmd.scan_step) begin
        cur <= cur_nx;
      end else if (cmd.pop) begin
        rp  <= rp_nx;
        cur <= rp_nx;
        cnt <= cnt_inc;
      end
      if (cmd.wr_append) begin
        wp <= wp_nx;
        if (wp_nx == rp) begin
          rp <= rp_nx;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/coalescing_update_queue.sv]
// Top level of the coalescing update queue: controller plus datapath.
// Enqueue: a rejected item is answered from the evaluate state; else the stored entries are
//   read and compared oldest first, a key match is overwritten, and with none it is appended.
// Drain: an empty queue gives one empty result; else entries go out oldest first, up to
//   drain_limit (0: all), each through the store's registered read port when output is free.
// A new item is accepted only when the previous one is finished and the output
//   register is free or being taken. Reset: pointers, state and output valid clear;
//   the entry store is not cleared, only entries between the pointers are read.
module coalescing_update_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cuq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cuq_pkg::out_item_t out_data
);
  import cuq_pkg::*;

  cuq_cmd_t  cmd;   // sequencing commands to the datapath
  cuq_stat_t stat;  // compare and pointer flags back to the controller

  cuq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cuq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one still in work");

  // accept only when the output register can take a fresh result
  a_out_free_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("accept while an unread result blocks the output");

  // anything but a delivered entry is a single, final, zero-field result
  a_non_delivery_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_DELIVERED) |->
      out_data.last && (out_data.out_payload_handle == '0) &&
      (out_data.out_slot_index == '0))
    else $error("malformed non-delivery result");

endmodule

[bench/tb.sv]
// Self-checking testbench for the coalescing update queue.
`timescale 1ns / 1ps

module tb;
  import cuq_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  always #10 clk = ~clk;

  coalescing_update_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  localparam int RANDOM_ITEMS = 254;
  localparam int DRAIN_WAIT_AT = 140;  // sender waits for every owed result here
  localparam int HOLD_AT = 80;         // receiver stalls for a long stretch here
  localparam int HOLD_CYCLES = 400;

  // Directed rows: typed rows carry their one obvious status, the rest go to the
  // predictor.
  typedef struct {
    in_item_t   item;
    bit         typed;
    logic [2:0] status;
  } stim_row_t;

  stim_row_t directed_rows [26] = '{
    // drain right after reset: nothing queued
    '{'{CMD_DRAIN,   3'd0, 8'd0,   32'h0000_0000, 8'd0},   1'b1, ST_EMPTY},
    // slot at the tile limit, slot at its top, null handle
    '{'{CMD_ENQUEUE, 3'd0, 8'd32,  32'h0000_0005, 8'd0},   1'b1, ST_REJECTED},
    '{'{CMD_ENQUEUE, 3'd7, 8'd255, 32'hFFFF_FFFF, 8'd255}, 1'b1, ST_REJECTED},
    '{'{CMD_ENQUEUE, 3'd0, 8'd0,   32'h0000_0000, 8'd0},   1'b1, ST_REJECTED},
    // key extremes, then a replace of the older one
    '{'{CMD_ENQUEUE, 3'd7, 8'd31,  32'hFFFF_FFFF, 8'd0},   1'b1, ST_APPENDED},
    '{'{CMD_ENQUEUE, 3'd0, 8'd0,   32'h0000_0001, 8'd0},   1'b1, ST_APPENDED},
    '{'{CMD_ENQUEUE, 3'd7, 8'd31,  32'h5A5A_A5A5, 8'd0},   1'b1, ST_COALESCED},
    '{'{CMD_DRAIN,   3'd0, 8'd0,   32'h0000_0000, 8'd255}, 1'b0, ST_EMPTY},
    '{'{CMD_DRAIN,   3'd7, 8'd255, 32'hFFFF_FFFF, 8'd0},   1'b1, ST_EMPTY},
    // fill the ring to its 15 usable entries
    '{'{CMD_ENQUEUE, 3'd0, 8'd1,   32'h0000_0100, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd1, 8'd3,   32'h0000_0201, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd2, 8'd5,   32'h0000_0402, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd3, 8'd7,   32'h0000_0803, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd4, 8'd9,   32'h0000_1004, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd5, 8'd11,  32'h0000_2005, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd6, 8'd13,  32'h0000_4006, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd7, 8'd15,  32'h0000_8007, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd0, 8'd17,  32'h0001_0008, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd1, 8'd19,  32'h0002_0009, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd2, 8'd21,  32'h0004_000A, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd3, 8'd23,  32'h0008_000B, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd4, 8'd25,  32'h0010_000C, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd5, 8'd27,  32'h0020_000D, 8'd0},   1'b0, ST_EMPTY},
    '{'{CMD_ENQUEUE, 3'd6, 8'd29,  32'h0040_000E, 8'd0},   1'b0, ST_EMPTY},
    // ring full: the oldest entry goes
    '{'{CMD_ENQUEUE, 3'd5, 8'd30,  32'h8000_000F, 8'd0},   1'b1, ST_DROPPED},
    // drain all 15
    '{'{CMD_DRAIN,   3'd0, 8'd0,   32'h0000_0000, 8'd0},   1'b0, ST_EMPTY}
  };

  // Predictor state: the pending ring and its pointers.
  entry_t    ring_entries [QUEUE_SLOTS];
  int        oldest_idx;
  int        free_idx;
  out_item_t step_results [$];   // results of the latest predicted item
  out_item_t due_results [$];    // results still owed by the block, oldest first

  int items_sent;
  int results_seen;
  int mismatches;

  // Apply one item to the predicted ring; leaves its results in step_results.
  task automatic predict_queue_step(input in_item_t it);
    logic [HANDLE_BITS-1:0] h;
    out_item_t              r;
    bit                     hit;
    int                     p;
    int                     n;
    h = HANDLE_BITS'(it.payload_handle);
    step_results.delete();
    r = '0;
    r.last = 1'b1;
    if (it.cmd == CMD_ENQUEUE) begin
      if (it.slot_index >= TILE_LIMIT || h == '0) begin
        r.status = ST_REJECTED;
      end else begin
        hit = 1'b0;
        // oldest to newest; first key match takes the new handle
        for (p = oldest_idx; p != free_idx && !hit; p = (p + 1) % QUEUE_SLOTS) begin
          if (ring_entries[p].group_kind == it.group_kind &&
              ring_entries[p].slot_index == it.slot_index) begin
            ring_entries[p].handle = h;
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.status = ST_COALESCED;
        end else begin
          r.status = ST_APPENDED;
          // one slot stays free, so a full ring loses its oldest entry
          if ((free_idx + 1) % QUEUE_SLOTS == oldest_idx) begin
            oldest_idx = (oldest_idx + 1) % QUEUE_SLOTS;
            r.status = ST_DROPPED;
          end
          ring_entries[free_idx].group_kind = it.group_kind;
          ring_entries[free_idx].slot_index = it.slot_index;
          ring_entries[free_idx].handle     = h;
          free_idx = (free_idx + 1) % QUEUE_SLOTS;
        end
      end
      step_results.push_back(r);
    end else if (oldest_idx == free_idx) begin
      r.status = ST_EMPTY;
      step_results.push_back(r);
    end else begin
      n = 0;
      while (oldest_idx != free_idx && (it.drain_limit == 0 || n < it.drain_limit)) begin
        r.status             = ST_DELIVERED;
        r.out_group_kind     = ring_entries[oldest_idx].group_kind;
        r.out_slot_index     = ring_entries[oldest_idx].slot_index;
        r.out_payload_handle = 32'(ring_entries[oldest_idx].handle);
        r.last               = 1'b0;
        step_results.push_back(r);
        oldest_idx = (oldest_idx + 1) % QUEUE_SLOTS;
        n++;
      end
      step_results[step_results.size() - 1].last = 1'b1;
    end
  endtask

  // Mostly well-formed enqueues over a small hot key set, some rejects, drains
  // with no limit, a short limit or a random one.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.cmd            = CMD_ENQUEUE;
    it.group_kind     = 3'($urandom);
    it.slot_index     = 8'($urandom_range(0, TILE_LIMIT - 1));
    it.payload_handle = $urandom;
    it.drain_limit    = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      if ($urandom_range(0, 1) == 1) begin
        it.group_kind = 3'($urandom_range(0, 1));
        it.slot_index = 8'($urandom_range(0, 5));
      end
      if (it.payload_handle == 32'd0) it.payload_handle = 32'd1;
    end else if (pick < 70) begin
      if ($urandom_range(0, 1) == 1) it.slot_index = 8'($urandom_range(TILE_LIMIT, 255));
      else it.payload_handle = 32'd0;
    end else begin
      it.cmd = CMD_DRAIN;
      pick = $urandom_range(0, 9);
      if (pick < 4) it.drain_limit = 8'd0;
      else if (pick < 8) it.drain_limit = 8'($urandom_range(1, 4));
      else it.slot_index = 8'($urandom);  // noise in fields a drain ignores
    end
    return it;
  endfunction

  // Hold one item on the input until taken, then queue what it owes.
  task automatic offer(input in_item_t it, input bit typed, input logic [2:0] st);
    out_item_t r;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_queue_step(it);
    if (typed) begin
      r = '0;
      r.status = st;
      r.last   = 1'b1;
      due_results.push_back(r);
    end else begin
      foreach (step_results[k]) due_results.push_back(step_results[k]);
    end
    @(negedge clk);
  endtask

  // Gap before the next item; a burst window with no gaps, and one point where
  // the sender waits for every owed result.
  task automatic pace();
    int gap;
    gap = (items_sent >= 180 && items_sent < 215) ? 0 : $urandom_range(0, 12);
    if (items_sent == DRAIN_WAIT_AT && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (items_sent == DRAIN_WAIT_AT) begin
      while (due_results.size() != 0) @(negedge clk);
    end
  endtask

  // Sender and end of run.
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    oldest_idx   = 0;
    free_idx     = 0;
    items_sent   = 0;
    mismatches   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].status);
      pace();
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      offer(random_item(), 1'b0, ST_EMPTY);
      if (i < RANDOM_ITEMS - 1) pace();
    end
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    // wait on, so that a stray extra result can still show up
    repeat (50) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold, a window with none; checks each result.
  initial begin
    int        stall;
    out_item_t want;
    out_ready    = 1'b0;
    results_seen = 0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      else if (results_seen >= 300 && results_seen < 340) stall = 0;
      else stall = $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (due_results.size() == 0) begin
        $error("unexpected result, status %0d", out_data.status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.out_group_kind !== want.out_group_kind) begin
          $error("out_group_kind: expected %0d, got %0d",
                 want.out_group_kind, out_data.out_group_kind);
          mismatches++;
        end
        if (out_data.out_slot_index !== want.out_slot_index) begin
          $error("out_slot_index: expected %0d, got %0d",
                 want.out_slot_index, out_data.out_slot_index);
          mismatches++;
        end
        if (out_data.out_payload_handle !== want.out_payload_handle) begin
          $error("out_payload_handle: expected %h, got %h",
                 want.out_payload_handle, out_data.out_payload_handle);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          mismatches++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
hdl/cuq_pkg.sv
hdl/cuq_ram.sv
hdl/cuq_ctrl.sv
hdl/cuq_datapath.sv
hdl/coalescing_update_queue.sv
bench/tb.sv
